// ===== rtl/core/csh_pkg.sv =====
// Shared types, constants and sine table helpers for the cone sector hit test.
package csh_pkg;

   // Field widths
   localparam int COORD_W   = 24;
   localparam int DELTA_W   = COORD_W + 1;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int DIST_W    = 2 * COORD_W + 1;
   localparam int REACH_W   = 23;
   localparam int REACH2_W  = 2 * REACH_W;
   localparam int FACING_W  = 12;
   localparam int HALF_W    = 11;
   localparam int VERDICT_W = 3;
   localparam int THRESH_W  = 16;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_NEAR_THRESHOLD = 1'b0;
   localparam logic [THRESH_W-1:0] NEAR_THRESHOLD_RESET = 16'd6;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_BEYOND  = 3'd0,
      VERDICT_NEAR    = 3'd1,
      VERDICT_BEHIND  = 3'd2,
      VERDICT_OUTSIDE = 3'd3,
      VERDICT_INSIDE  = 3'd4
   } verdict_type;

   typedef struct packed {
      logic                  psel;
      logic                  penable;
      logic                  pwrite;
      logic [CSR_ADDR_W-1:0] paddr;
      logic [CSR_DATA_W-1:0] pwdata;
   } csr_req_type;

   // Odd polynomial for sin over a quarter turn, Q30
   localparam longint SIN_COEF [6] = '{
      64'sd1686629713, -64'sd693598669, 64'sd85569306,
      -64'sd5026995, 64'sd172272, -64'sd3864
   };

   // Q30 product, magnitude truncated toward zero
   function automatic longint qmul30(longint a, longint b);
      logic        neg;
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] m;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? 64'(-a) : 64'(a);
      mb  = (b < 0) ? 64'(-b) : 64'(b);
      m   = (ma * mb) >> 30;
      return neg ? -$signed(m) : $signed(m);
   endfunction

   // sin(pi/2 * r / 2^(angle_bits-2)), rounded to trig_bits-1 fraction bits;
   // evaluated at elaboration to fill the sine table
   function automatic longint quarter_sine(int angle_bits, int trig_bits, longint r);
      longint t;
      longint u;
      longint p;
      longint one;
      int     shift;
      int     i;
      shift = 31 - trig_bits;
      one   = longint'(1) <<< (trig_bits - 1);
      t     = r <<< (30 - (angle_bits - 2));
      u     = qmul30(t, t);
      p     = SIN_COEF[5];
      for (i = 4; i >= 0; i--) begin
         p = SIN_COEF[i] + qmul30(p, u);
      end
      p = qmul30(t, p);
      if (p < 0) begin
         p = 0;
      end
      p = (p + (longint'(1) <<< (shift - 1))) >>> shift;
      return (p > one) ? one : p;
   endfunction

endpackage

// ===== rtl/core/csh_ifs.sv =====
// Valid/ready channel interfaces for query words and result words.
interface csh_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [csh_pkg::COORD_W-1:0]  attacker_x;
   logic signed [csh_pkg::COORD_W-1:0]  attacker_y;
   logic signed [csh_pkg::COORD_W-1:0]  target_x;
   logic signed [csh_pkg::COORD_W-1:0]  target_y;
   logic [csh_pkg::REACH_W-1:0]         reach;
   logic [csh_pkg::FACING_W-1:0]        facing;
   logic [csh_pkg::HALF_W-1:0]          half_angle;

   modport source (
      output valid, attacker_x, attacker_y, target_x, target_y, reach, facing,
             half_angle,
      input  ready
   );
   modport sink (
      input  valid, attacker_x, attacker_y, target_x, target_y, reach, facing,
             half_angle,
      output ready
   );
endinterface

interface csh_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            hit;
   logic [csh_pkg::VERDICT_W-1:0]   verdict;

   modport source (output valid, hit, verdict, input ready);
   modport sink (input valid, hit, verdict, output ready);
endinterface

// ===== rtl/core/csh_sine_rom.sv =====
// Quarter-turn sine table with one registered read port.
module csh_sine_rom #(
   parameter int ANGLE_BITS = 12,
   parameter int TRIG_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [ANGLE_BITS-2:0] rd_addr,
   output logic [TRIG_BITS-1:0]  rd_data
);

   localparam int QUARTER = 1 << (ANGLE_BITS - 2);
   localparam int DEPTH   = QUARTER + 1;

   typedef logic [TRIG_BITS-1:0] sine_rom_type [DEPTH];

   function automatic sine_rom_type build_table();
      sine_rom_type tbl;
      for (int i = 0; i < DEPTH; i++) begin
         tbl[i] = TRIG_BITS'(csh_pkg::quarter_sine(ANGLE_BITS, TRIG_BITS, longint'(i)));
      end
      return tbl;
   endfunction

   localparam sine_rom_type SINE_ROM = build_table();

   logic [TRIG_BITS-1:0] rd_data_ff;

   // registered read, held while the stage stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SINE_ROM[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/csh_csr.sv =====
// Configuration register block: near threshold, APB-style write and read.
module csh_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  csh_pkg::csr_req_type             csr_req,
   output logic [csh_pkg::CSR_DATA_W-1:0]   prdata,
   output logic [csh_pkg::THRESH_W-1:0]     near_threshold
);

   logic [csh_pkg::THRESH_W-1:0] near_threshold_ff;
   logic [csh_pkg::THRESH_W-1:0] near_threshold_in;
   logic                         reg_sel;
   logic                         wr_strobe;

   // word index lives above the byte offset
   assign reg_sel   = (csr_req.paddr[csh_pkg::CSR_ADDR_W-1:2] == csh_pkg::REG_NEAR_THRESHOLD);
   assign wr_strobe = csr_req.psel && csr_req.penable && csr_req.pwrite;

   always_comb begin
      near_threshold_in = near_threshold_ff;
      if (wr_strobe && reg_sel) begin
         near_threshold_in = csr_req.pwdata[csh_pkg::THRESH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_threshold_ff <= csh_pkg::NEAR_THRESHOLD_RESET;
      end else begin
         near_threshold_ff <= near_threshold_in;
      end
   end

   // read mux, unmapped words read zero
   assign prdata = reg_sel ? csh_pkg::CSR_DATA_W'(near_threshold_ff) : '0;

   assign near_threshold = near_threshold_ff;

endmodule

// ===== rtl/core/cone_sector_hit_test.sv =====
// Cone sector hit test: seven-stage pipeline deciding if a target lies in a cone.
// Each accepted query word passes through stages A to G to its result word on rsp_chan.
// Throughput: one word per cycle; stages collapse bubbles, a full pipe stalls as a unit.
// Pace is set by the multiplier stages and the sine table read in the first stage.
// Reset clears all stage valid bits and sets near_threshold to 6; no table clear pass.
module cone_sector_hit_test #(
   parameter int ANGLE_BITS = 12,
   parameter int TRIG_BITS  = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   csh_req_if.sink                          req_chan,
   csh_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [csh_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [csh_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [csh_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int NSTAGE    = 7;
   localparam int ROM_AW    = ANGLE_BITS - 1;
   localparam int QUARTER   = 1 << (ANGLE_BITS - 2);
   localparam int TW        = TRIG_BITS;
   localparam int TRIG_S_W  = TW + 1;
   localparam int DELTA_W   = csh_pkg::DELTA_W;
   localparam int PROD_W    = DELTA_W + TRIG_S_W;
   localparam int DOTM_W    = TW + 24;
   localparam int DOT_LO_W  = (DOTM_W + 1) / 2;
   localparam int DOT_HI_W  = DOTM_W - DOT_LO_W;
   localparam int DIST_W    = csh_pkg::DIST_W;
   localparam int DIST_LO_W = (DIST_W + 1) / 2;
   localparam int DIST_HI_W = DIST_W - DIST_LO_W;
   localparam int CH2_W     = 2 * TW;
   localparam int CH2_LO_W  = (CH2_W + 1) / 2;
   localparam int CH2_HI_W  = CH2_W - CH2_LO_W;
   localparam int LHS_W     = 2 * DOTM_W;
   localparam int RHS_W     = DIST_W + CH2_W;
   localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   typedef struct packed {
      logic beyond;
      logic near;
      logic front;
   } flag_type;

   // ---------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------
   csh_pkg::csr_req_type           csr_req;
   logic [csh_pkg::THRESH_W-1:0]   near_threshold;

   assign csr_req = '{psel: csr_psel, penable: csr_penable, pwrite: csr_pwrite,
                      paddr: csr_paddr, pwdata: csr_pwdata};
   assign csr_pready = 1'b1;

   csh_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_req        (csr_req),
      .prdata         (csr_prdata),
      .near_threshold (near_threshold)
   );

   // ---------------------------------------------------------------
   // Stage valids and per-stage advance
   // ---------------------------------------------------------------
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] en;

   always_comb begin
      en[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_chan.ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < NSTAGE; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_chan.ready = en[0];
   assign rsp_chan.valid = vld_ff[NSTAGE-1];

   // ---------------------------------------------------------------
   // Stage A: deltas, table addresses (table read registers here)
   // ---------------------------------------------------------------
   logic [ANGLE_BITS-1:0]   fac_ang;
   logic [ANGLE_BITS-1:0]   cos_ang;
   logic [ROM_AW-1:0]       sin_addr;
   logic [ROM_AW-1:0]       cos_addr;
   logic [ROM_AW-1:0]       half_sat;
   logic [ROM_AW-1:0]       ch_addr;
   logic                    half_big;

   logic signed [DELTA_W-1:0]      dx_a_in, dx_a_ff, dy_a_in, dy_a_ff;
   logic [csh_pkg::REACH_W-1:0]    reach_a_ff;
   logic                           sneg_a_in, sneg_a_ff, cneg_a_in, cneg_a_ff;
   logic [TW-1:0]                  sin_mag, cos_mag, ch_mag;

   always_comb begin
      fac_ang  = ANGLE_BITS'(req_chan.facing);
      cos_ang  = fac_ang + ANGLE_BITS'(QUARTER);
      // odd quadrants read the table mirrored
      sin_addr = fac_ang[ANGLE_BITS-2] ?
                 (ROM_AW'(QUARTER) - {1'b0, fac_ang[ANGLE_BITS-3:0]}) :
                 {1'b0, fac_ang[ANGLE_BITS-3:0]};
      cos_addr = cos_ang[ANGLE_BITS-2] ?
                 (ROM_AW'(QUARTER) - {1'b0, cos_ang[ANGLE_BITS-3:0]}) :
                 {1'b0, cos_ang[ANGLE_BITS-3:0]};
      sneg_a_in = fac_ang[ANGLE_BITS-1];
      cneg_a_in = cos_ang[ANGLE_BITS-1];
      // half angle clamps at a quarter turn; cos(h) = S(quarter - h)
      half_big = (32'(req_chan.half_angle) > 32'(QUARTER));
      half_sat = half_big ? ROM_AW'(QUARTER) : ROM_AW'(req_chan.half_angle);
      ch_addr  = ROM_AW'(QUARTER) - half_sat;
      dx_a_in  = {req_chan.target_x[csh_pkg::COORD_W-1], req_chan.target_x} -
                 {req_chan.attacker_x[csh_pkg::COORD_W-1], req_chan.attacker_x};
      dy_a_in  = {req_chan.target_y[csh_pkg::COORD_W-1], req_chan.target_y} -
                 {req_chan.attacker_y[csh_pkg::COORD_W-1], req_chan.attacker_y};
   end

   csh_sine_rom #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_rom_sin (
      .clock (clock), .rd_en (en[0]), .rd_addr (sin_addr), .rd_data (sin_mag)
   );
   csh_sine_rom #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_rom_cos (
      .clock (clock), .rd_en (en[0]), .rd_addr (cos_addr), .rd_data (cos_mag)
   );
   csh_sine_rom #(.ANGLE_BITS(ANGLE_BITS), .TRIG_BITS(TRIG_BITS)) u_rom_half (
      .clock (clock), .rd_en (en[0]), .rd_addr (ch_addr), .rd_data (ch_mag)
   );

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dx_a_ff    <= dx_a_in;
         dy_a_ff    <= dy_a_in;
         reach_a_ff <= req_chan.reach;
         sneg_a_ff  <= sneg_a_in;
         cneg_a_ff  <= cneg_a_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage B: squares, signed trig values
   // ---------------------------------------------------------------
   logic signed [2*DELTA_W-1:0]    sqx_full, sqy_full;
   logic [csh_pkg::SQ_W-1:0]       dx2_b_ff, dy2_b_ff;
   logic [csh_pkg::REACH2_W-1:0]   reach2_b_in, reach2_b_ff;
   logic signed [TRIG_S_W-1:0]     fc_b_in, fc_b_ff, fs_b_in, fs_b_ff;
   logic [TW-1:0]                  ch_b_ff;
   logic signed [DELTA_W-1:0]      dx_b_ff, dy_b_ff;

   always_comb begin
      sqx_full    = dx_a_ff * dx_a_ff;
      sqy_full    = dy_a_ff * dy_a_ff;
      reach2_b_in = reach_a_ff * reach_a_ff;
      fc_b_in     = cneg_a_ff ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
      fs_b_in     = sneg_a_ff ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dx2_b_ff    <= sqx_full[csh_pkg::SQ_W-1:0];
         dy2_b_ff    <= sqy_full[csh_pkg::SQ_W-1:0];
         reach2_b_ff <= reach2_b_in;
         fc_b_ff     <= fc_b_in;
         fs_b_ff     <= fs_b_in;
         ch_b_ff     <= ch_mag;
         dx_b_ff     <= dx_a_ff;
         dy_b_ff     <= dy_a_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage C: squared distance, projection products, cos^2 of half angle
   // ---------------------------------------------------------------
   logic [DIST_W-1:0]              dist2_c_in, dist2_c_ff;
   logic [csh_pkg::REACH2_W-1:0]   reach2_c_ff;
   logic signed [PROD_W-1:0]       px_c_in, px_c_ff, py_c_in, py_c_ff;
   logic [CH2_W-1:0]               ch2_c_in, ch2_c_ff;

   always_comb begin
      dist2_c_in = {1'b0, dx2_b_ff} + {1'b0, dy2_b_ff};
      px_c_in    = dx_b_ff * fc_b_ff;
      py_c_in    = dy_b_ff * fs_b_ff;
      ch2_c_in   = ch_b_ff * ch_b_ff;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         dist2_c_ff  <= dist2_c_in;
         reach2_c_ff <= reach2_b_ff;
         px_c_ff     <= px_c_in;
         py_c_ff     <= py_c_in;
         ch2_c_ff    <= ch2_c_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage D: dot product, range and near checks
   // ---------------------------------------------------------------
   logic signed [PROD_W-1:0]  dot_d_in, dot_d_ff;
   logic                      beyond_d_in, near_d_in;
   logic                      beyond_d_ff, near_d_ff;
   logic [DIST_W-1:0]         dist2_d_ff;
   logic [CH2_W-1:0]          ch2_d_ff;

   always_comb begin
      dot_d_in    = px_c_ff + py_c_ff;
      beyond_d_in = dist2_c_ff > DIST_W'(reach2_c_ff);
      near_d_in   = dist2_c_ff <= DIST_W'(near_threshold);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         dot_d_ff    <= dot_d_in;
         beyond_d_ff <= beyond_d_in;
         near_d_ff   <= near_d_in;
         dist2_d_ff  <= dist2_c_ff;
         ch2_d_ff    <= ch2_c_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage E: partial products of dot^2 and dist2 * cos^2
   // ---------------------------------------------------------------
   logic [DOTM_W-1:0]                dotm;
   logic [DOT_LO_W-1:0]              dot_lo;
   logic [DOT_HI_W-1:0]              dot_hi;
   logic [2*DOT_HI_W-1:0]            pp_hh_in, pp_hh_ff;
   logic [DOT_HI_W+DOT_LO_W-1:0]     pp_hl_in, pp_hl_ff;
   logic [2*DOT_LO_W-1:0]            pp_ll_in, pp_ll_ff;
   logic [DIST_LO_W-1:0]             dist_lo;
   logic [DIST_HI_W-1:0]             dist_hi;
   logic [CH2_LO_W-1:0]              ch2_lo;
   logic [CH2_HI_W-1:0]              ch2_hi;
   logic [DIST_HI_W+CH2_HI_W-1:0]    q_hh_in, q_hh_ff;
   logic [DIST_HI_W+CH2_LO_W-1:0]    q_hl_in, q_hl_ff;
   logic [DIST_LO_W+CH2_HI_W-1:0]    q_lh_in, q_lh_ff;
   logic [DIST_LO_W+CH2_LO_W-1:0]    q_ll_in, q_ll_ff;
   flag_type                         flags_e_in, flags_e_ff;

   always_comb begin
      // magnitude is only used when the dot product is positive
      dotm     = dot_d_ff[DOTM_W-1:0];
      dot_lo   = dotm[DOT_LO_W-1:0];
      dot_hi   = dotm[DOTM_W-1:DOT_LO_W];
      pp_hh_in = dot_hi * dot_hi;
      pp_hl_in = dot_hi * dot_lo;
      pp_ll_in = dot_lo * dot_lo;
      dist_lo  = dist2_d_ff[DIST_LO_W-1:0];
      dist_hi  = dist2_d_ff[DIST_W-1:DIST_LO_W];
      ch2_lo   = ch2_d_ff[CH2_LO_W-1:0];
      ch2_hi   = ch2_d_ff[CH2_W-1:CH2_LO_W];
      q_hh_in  = dist_hi * ch2_hi;
      q_hl_in  = dist_hi * ch2_lo;
      q_lh_in  = dist_lo * ch2_hi;
      q_ll_in  = dist_lo * ch2_lo;
      flags_e_in.beyond = beyond_d_ff;
      flags_e_in.near   = near_d_ff;
      flags_e_in.front  = !dot_d_ff[PROD_W-1] && (dot_d_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         pp_hh_ff   <= pp_hh_in;
         pp_hl_ff   <= pp_hl_in;
         pp_ll_ff   <= pp_ll_in;
         q_hh_ff    <= q_hh_in;
         q_hl_ff    <= q_hl_in;
         q_lh_ff    <= q_lh_in;
         q_ll_ff    <= q_ll_in;
         flags_e_ff <= flags_e_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage F: assemble both sides of the angle compare
   // ---------------------------------------------------------------
   logic [CMP_W-1:0] lhs_f_in, lhs_f_ff, rhs_f_in, rhs_f_ff;
   flag_type         flags_f_ff;

   always_comb begin
      lhs_f_in = (CMP_W'(pp_hh_ff) << (2 * DOT_LO_W)) +
                 (CMP_W'(pp_hl_ff) << (DOT_LO_W + 1)) +
                 CMP_W'(pp_ll_ff);
      rhs_f_in = (CMP_W'(q_hh_ff) << (DIST_LO_W + CH2_LO_W)) +
                 (CMP_W'(q_hl_ff) << DIST_LO_W) +
                 (CMP_W'(q_lh_ff) << CH2_LO_W) +
                 CMP_W'(q_ll_ff);
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         lhs_f_ff   <= lhs_f_in;
         rhs_f_ff   <= rhs_f_in;
         flags_f_ff <= flags_e_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage G: verdict into the output register
   // ---------------------------------------------------------------
   csh_pkg::verdict_type verdict_g_in, verdict_g_ff;
   logic                 hit_g_in, hit_g_ff;

   always_comb begin
      priority if (flags_f_ff.beyond) begin
         verdict_g_in = csh_pkg::VERDICT_BEYOND;
      end else if (flags_f_ff.near) begin
         verdict_g_in = csh_pkg::VERDICT_NEAR;
      end else if (!flags_f_ff.front) begin
         verdict_g_in = csh_pkg::VERDICT_BEHIND;
      end else if (lhs_f_ff >= rhs_f_ff) begin
         verdict_g_in = csh_pkg::VERDICT_INSIDE;
      end else begin
         verdict_g_in = csh_pkg::VERDICT_OUTSIDE;
      end
      hit_g_in = (verdict_g_in == csh_pkg::VERDICT_NEAR) ||
                 (verdict_g_in == csh_pkg::VERDICT_INSIDE);
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         verdict_g_ff <= verdict_g_in;
         hit_g_ff     <= hit_g_in;
      end
   end

   assign rsp_chan.verdict = verdict_g_ff;
   assign rsp_chan.hit     = hit_g_ff;

`ifndef ASSERT_OFF
   // hit flag must agree with the verdict code
   a_hit_matches_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.hit == ((rsp_chan.verdict == csh_pkg::VERDICT_NEAR) ||
                           (rsp_chan.verdict == csh_pkg::VERDICT_INSIDE))))
      else $error("hit flag disagrees with verdict");

   // input is refused only when every stage holds a word
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (&vld_ff))
      else $error("input stalled with a bubble in the pipe");

   // a blocked middle stage keeps its word
   a_mid_stage_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && !en[3] |=> vld_ff[3])
      else $error("stalled stage dropped its word");
`endif

endmodule
